// ===== sv/pftm_pkg.sv =====
// Package for the page frame and table manager: sizes, command codes and status codes.
// It depends on nothing. The top level imports it.
package pftm_pkg;
    localparam int FRAME_BITS    = 8;
    localparam int IDX_BITS      = 10;
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int FRAME_COUNT   = 1 << FRAME_BITS;

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_ALLOC = 3'd1;
    localparam logic [2:0] CMD_FREE  = 3'd2;
    localparam logic [2:0] CMD_MAP   = 3'd3;
    localparam logic [2:0] CMD_UNMAP = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_OOM    = 2'd2;

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_LAST  = 1'b1;

    typedef logic [FRAME_BITS-1:0] frame_t;
endpackage

// ===== sv/page_frame_and_table_manager.sv =====
// Top level of the page frame and table manager: a free-frame stack and a two-level page table.
// It depends on pftm_pkg. All memories are arrays inside this module.
//
// The block takes one command beat at a time and answers each one with exactly one result beat.
// A small sequencer steps through each command; the directory, table and link memories are read
// in parallel every cycle. Alloc, free and every quick answer pass through RD, DEC and OUT.
// Init links one frame per cycle, from the first to the last frame, before it gives its result.
// A map that installs a new table clears that table one entry per cycle, then gives its result.
// An unmap scans the table entry by entry until it finds a present entry; if there is none,
// it returns the table's frame to the free stack and clears the directory entry. The output
// register holds the result until it is taken; the next command is accepted in the cycle
// after that result has left. After reset the directory is cleared one entry per cycle,
// while no command is accepted. Configuration writes are taken at any time.
module page_frame_and_table_manager
    import pftm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd[2:0], frame[10:3], vpage[30:11], zero[31]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], result_frame[9:2], tlb_flush[10], zero[15:11]
);
    localparam int TW = 2 * IDX_BITS;
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_INIT  = 4'd5;
    localparam logic [3:0] S_TCLR  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_SCHK  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_MPOP  = 4'd10;

    logic [FRAME_BITS:0] dir_mem [DIR_ENTRIES];
    logic [FRAME_BITS:0] tbl_mem [DIR_ENTRIES*TABLE_ENTRIES];
    frame_t              link_mem [FRAME_COUNT];

    logic [3:0]  state_reg;
    logic [IDX_BITS:0] cnt_reg;
    logic [7:0]  first_reg, last_reg;
    frame_t      head_reg;
    logic [2:0]  cmd_reg;
    frame_t      frame_reg;
    logic [19:0] vpage_reg;
    frame_t      f_reg, last_f_reg;
    logic [FRAME_BITS:0] dir_rd_reg, tbl_rd_reg;
    frame_t      link_rd_reg;
    logic [1:0]  st_reg;
    frame_t      res_reg;
    logic        fl_reg;
    logic        ov_reg;

    logic [IDX_BITS-1:0] d_idx, t_idx;
    logic frame_ok;
    assign d_idx = vpage_reg[TW-1:IDX_BITS];
    assign t_idx = vpage_reg[IDX_BITS-1:0];
    assign frame_ok = frame_reg != '0;

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, fl_reg, res_reg, st_reg};

    // Memory reads are registered; addresses come from the command registers, the scan counter or the stack head.
    always_ff @(posedge clk)
    begin
        dir_rd_reg  <= dir_mem[d_idx];
        tbl_rd_reg  <= tbl_mem[{d_idx, (state_reg == S_SCAN) ? cnt_reg[IDX_BITS-1:0] : t_idx}];
        link_rd_reg <= link_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            dir_mem[cnt_reg[IDX_BITS-1:0]] <= '0;
        end
        if (state_reg == S_INIT)
        begin
            link_mem[f_reg] <= (f_reg == last_f_reg) ? '0 : f_reg + 1'b1;
        end
        if (state_reg == S_DEC && cmd_reg == CMD_FREE && frame_ok)
        begin
            link_mem[frame_reg] <= head_reg;
        end
        if (state_reg == S_SCHK && cnt_reg[IDX_BITS])
        begin
            link_mem[dir_rd_reg[FRAME_BITS-1:0]] <= head_reg;
        end
        if (state_reg == S_MPOP)
        begin
            dir_mem[d_idx] <= {1'b1, head_reg};
        end
        if (state_reg == S_SCHK && cnt_reg[IDX_BITS])
        begin
            dir_mem[d_idx] <= '0;
        end
        if (state_reg == S_TCLR)
        begin
            tbl_mem[{d_idx, cnt_reg[IDX_BITS-1:0]}] <=
                (cnt_reg[IDX_BITS-1:0] == t_idx) ? {1'b1, frame_reg} : '0;
        end
        if (state_reg == S_DEC && cmd_reg == CMD_MAP && dir_rd_reg[FRAME_BITS]
            && !tbl_rd_reg[FRAME_BITS] && frame_ok && vpage_reg != '0)
        begin
            tbl_mem[{d_idx, t_idx}] <= {1'b1, frame_reg};
        end
        if (state_reg == S_DEC && cmd_reg == CMD_UNMAP && dir_rd_reg[FRAME_BITS])
        begin
            tbl_mem[{d_idx, t_idx}] <= '0;
        end
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tdata[2:0];
            frame_reg <= s_tdata[10:3];
            vpage_reg <= s_tdata[30:11];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cnt_reg    <= '0;
            first_reg  <= 8'd1;
            last_reg   <= 8'd255;
            head_reg   <= '0;
            ov_reg     <= 1'b0;
            st_reg     <= ST_OK;
            res_reg    <= '0;
            fl_reg     <= 1'b0;
            f_reg      <= '0;
            last_f_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FIRST)
                    first_reg <= cfg_data;
                else
                    last_reg <= cfg_data;
            end
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[IDX_BITS-1:0] == IDX_BITS'(DIR_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    st_reg  <= ST_OK;
                    res_reg <= '0;
                    fl_reg  <= 1'b0;
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    state_reg <= S_OUT;
                    case (cmd_reg)
                        CMD_INIT:
                        begin
                            f_reg      <= (first_reg == '0) ? 8'd1 : first_reg;
                            last_f_reg <= last_reg;
                            if (((first_reg == '0) ? 8'd1 : first_reg) > last_reg)
                                head_reg <= '0;
                            else
                            begin
                                head_reg  <= (first_reg == '0) ? 8'd1 : first_reg;
                                state_reg <= S_INIT;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (head_reg == '0)
                                st_reg <= ST_OOM;
                            else
                            begin
                                res_reg  <= head_reg;
                                head_reg <= link_rd_reg;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (frame_ok)
                                head_reg <= frame_reg;
                            else
                                st_reg <= ST_REJECT;
                        end
                        CMD_MAP:
                        begin
                            if (!frame_ok || vpage_reg == '0)
                                st_reg <= ST_REJECT;
                            else if (dir_rd_reg[FRAME_BITS])
                            begin
                                if (tbl_rd_reg[FRAME_BITS])
                                    st_reg <= ST_REJECT;
                                else
                                    fl_reg <= 1'b1;
                            end
                            else if (head_reg == '0)
                                st_reg <= ST_OOM;
                            else
                                state_reg <= S_MPOP;
                        end
                        CMD_UNMAP:
                        begin
                            if (dir_rd_reg[FRAME_BITS])
                            begin
                                if (tbl_rd_reg[FRAME_BITS])
                                begin
                                    res_reg <= tbl_rd_reg[FRAME_BITS-1:0];
                                    fl_reg  <= 1'b1;
                                end
                                cnt_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            st_reg <= ST_REJECT;
                        end
                    endcase
                end
                S_MPOP:
                begin
                    head_reg  <= link_rd_reg;
                    fl_reg    <= 1'b1;
                    cnt_reg   <= '0;
                    state_reg <= S_TCLR;
                end
                S_TCLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[IDX_BITS-1:0] == IDX_BITS'(TABLE_ENTRIES - 1))
                        state_reg <= S_OUT;
                end
                S_INIT:
                begin
                    f_reg <= f_reg + 1'b1;
                    if (f_reg == last_f_reg)
                        state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    // Read data for the entry at cnt is now valid.
                    if (tbl_rd_reg[FRAME_BITS])
                        state_reg <= S_OUT;
                    else if (cnt_reg[IDX_BITS-1:0] == IDX_BITS'(TABLE_ENTRIES - 1))
                    begin
                        cnt_reg   <= {1'b1, {IDX_BITS{1'b0}}};
                        state_reg <= S_SCHK;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCHK:
                begin
                    head_reg  <= dir_rd_reg[FRAME_BITS-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
